FILE: design/sba_pkg.sv
package sba_pkg;

  localparam int MAX_SLABS   = 16;
  localparam int SLAB_BYTES  = 65536;
  localparam int BLOCK_ALIGN = 16;
  localparam int PAGE_BYTES  = 4096;

  localparam int IDX_W   = $clog2(MAX_SLABS);
  localparam int COUNT_W = $clog2(MAX_SLABS + 1);
  localparam int REQ_W   = 20;
  localparam int ADDR_W  = 21;
  localparam int CAP_W   = 22;
  localparam int TOTAL_W = 25;
  localparam int GRANT_W = 32;

  localparam logic [CAP_W-1:0] ALIGN_UNIT = CAP_W'(BLOCK_ALIGN);
  localparam logic [CAP_W-1:0] PAGE_UNIT  = CAP_W'(PAGE_BYTES);
  localparam logic [CAP_W-1:0] SLAB_SIZE  = CAP_W'(SLAB_BYTES);

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2
  } sba_status_t;

  typedef struct packed {
    logic fit_en;
    logic sel_en;
    logic commit;
  } sba_ctrl_t;

endpackage

FILE: design/sba_cell.sv
module sba_cell
  import sba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  sba_ctrl_t         ctrl,
  input  logic              valid,
  input  logic              open_here,
  input  logic [ADDR_W-1:0] need,
  input  logic [ADDR_W-1:0] cap_new,
  input  logic              taken_in,
  output logic              taken_out,
  output logic              win,
  output logic [ADDR_W-1:0] cursor
);

  logic [ADDR_W-1:0] capacity;
  logic              fit;
  logic [CAP_W-1:0]  end_addr;

  assign end_addr  = CAP_W'(cursor) + CAP_W'(need);
  assign taken_out = taken_in | fit;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit <= 1'b0;
      win <= 1'b0;
    end else begin
      if (ctrl.fit_en) begin
        fit <= valid && (end_addr <= CAP_W'(capacity));
      end
      if (ctrl.sel_en) begin
        win <= fit & ~taken_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (win) begin
        cursor <= end_addr[ADDR_W-1:0];
      end else if (open_here) begin
        capacity <= cap_new;
        cursor   <= need;
      end
    end
  end

endmodule

FILE: design/slab_bump_allocator.sv
// Slab bump allocator.
// A request is issued by raising start with request_bytes; it is taken at a
// clock edge where start is high and busy is low. The length is rounded up to
// the block alignment and the open slabs are searched from newest to oldest.
// Each slab lives in a cell of a chain; the cells test their own fit in
// S_FIT, then a found flag ripples down the chain in S_SEL, so the newest
// fitting slab wins. If none fits, a new slab is opened in the next free cell.
// An item passes through S_FIT, S_SEL and S_COMMIT: the result appears on
// the result ports, with done high, once the block is back in S_IDLE, and
// busy is low in that same cycle, so a new item can be taken at its end.
// done is high for exactly one cycle per item, and the receiver cannot stall.
// slabs_open, bytes_reserved, bytes_handed_out and grants show the running
// totals and are valid while done is high.
// A full slab table gives status 2 with slab index and offset zero and no
// change of state.
// Synchronous reset closes all slabs and clears the totals; it needs no
// clearing pass.
module slab_bump_allocator
  import sba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   request_bytes,
  output logic               done,
  output logic [1:0]         status,
  output logic [3:0]         slab_num,
  output logic [ADDR_W-1:0]  offset,
  output logic [4:0]         slabs_open,
  output logic [TOTAL_W-1:0] bytes_reserved,
  output logic [TOTAL_W-1:0] bytes_handed_out,
  output logic [GRANT_W-1:0] grants
);

  typedef enum logic [1:0] {S_IDLE, S_FIT, S_SEL, S_COMMIT} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   need;
  logic [CAP_W-1:0]    cap_new;
  logic                found;
  logic [COUNT_W-1:0]  open_count;
  logic [TOTAL_W-1:0]  reserved_total;
  logic [TOTAL_W-1:0]  used_total;
  logic [GRANT_W-1:0]  grant_total;

  sba_ctrl_t           ctrl;
  logic [MAX_SLABS:0]  taken;
  logic [MAX_SLABS-1:0] win;
  logic [MAX_SLABS-1:0] valid;
  logic [MAX_SLABS-1:0] open_here;
  logic [ADDR_W-1:0]   cursor [MAX_SLABS];

  logic [ADDR_W-1:0]   need_calc;
  logic [CAP_W-1:0]    base;
  logic [ADDR_W-1:0]   off_sel;
  logic [IDX_W-1:0]    idx_sel;
  logic                room;
  logic [TOTAL_W:0]    reserved_sum;
  logic [TOTAL_W:0]    used_sum;

  assign need_calc = ADDR_W'(((CAP_W'(request_bytes) + ALIGN_UNIT - CAP_W'(1)) / ALIGN_UNIT)
                     * ALIGN_UNIT);
  assign base      = (CAP_W'(need) < SLAB_SIZE) ? SLAB_SIZE : CAP_W'(need);
  assign room      = open_count < COUNT_W'(MAX_SLABS);

  assign reserved_sum = (TOTAL_W + 1)'(reserved_total) + (TOTAL_W + 1)'(cap_new);
  assign used_sum     = (TOTAL_W + 1)'(used_total) + (TOTAL_W + 1)'(need);

  assign ctrl.fit_en = (state == S_FIT);
  assign ctrl.sel_en = (state == S_SEL);
  assign ctrl.commit = (state == S_COMMIT);

  assign busy = (state != S_IDLE);
  assign taken[MAX_SLABS] = 1'b0;

  always_comb begin
    off_sel = '0;
    idx_sel = '0;
    for (int k = 0; k < MAX_SLABS; k++) begin
      valid[k]     = COUNT_W'(k) < open_count;
      open_here[k] = (COUNT_W'(k) == open_count) && !found;
      if (win[k]) begin
        off_sel = off_sel | cursor[k];
        idx_sel = idx_sel | IDX_W'(k);
      end
    end
  end

  for (genvar g = 0; g < MAX_SLABS; g++) begin : g_cell
    sba_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .valid     (valid[g]),
      .open_here (open_here[g]),
      .need      (need),
      .cap_new   (cap_new[ADDR_W-1:0]),
      .taken_in  (taken[g+1]),
      .taken_out (taken[g]),
      .win       (win[g]),
      .cursor    (cursor[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      found          <= 1'b0;
      open_count     <= '0;
      reserved_total <= '0;
      used_total     <= '0;
      grant_total    <= '0;
    end else begin
      done <= (state == S_COMMIT);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            need  <= need_calc;
            state <= S_FIT;
          end
        end
        S_FIT: begin
          cap_new <= ((base + PAGE_UNIT - CAP_W'(1)) / PAGE_UNIT) * PAGE_UNIT;
          state   <= S_SEL;
        end
        S_SEL: begin
          found <= taken[0];
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          state <= S_IDLE;
          if (found) begin
            status     <= ST_EXISTING;
            slab_num   <= 4'(idx_sel);
            offset     <= off_sel;
          end else if (room) begin
            status     <= ST_NEW;
            slab_num   <= 4'(open_count);
            offset     <= '0;
            open_count <= open_count + COUNT_W'(1);
            reserved_total <= reserved_sum[TOTAL_W] ? '1 : reserved_sum[TOTAL_W-1:0];
          end else begin
            status     <= ST_FULL;
            slab_num   <= '0;
            offset     <= '0;
          end
          if (found || room) begin
            used_total <= used_sum[TOTAL_W] ? '1 : used_sum[TOTAL_W-1:0];
            if (grant_total != '1) begin
              grant_total <= grant_total + GRANT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign slabs_open       = 5'(open_count);
  assign bytes_reserved   = reserved_total;
  assign bytes_handed_out = used_total;
  assign grants           = grant_total;

endmodule

FILE: design/sba_checker.sv
module sba_checker
  import sba_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [3:0]         slab_num,
  input logic [ADDR_W-1:0]  offset,
  input logic [4:0]         slabs_open,
  input logic [TOTAL_W-1:0] bytes_reserved,
  input logic [TOTAL_W-1:0] bytes_handed_out,
  input logic [GRANT_W-1:0] grants
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("Result did not arrive four cycles after the item was taken.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result shown while the block is still busy.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (slabs_open == 5'(MAX_SLABS) && slab_num == 4'd0
                                      && offset == '0))
    else $error("Full status reported with free slabs or a nonzero placement.");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    (!done && !$past(rst)) |-> ($stable(grants) && $stable(bytes_reserved)
                                && $stable(slabs_open) && $stable(bytes_handed_out)))
    else $error("Totals changed without a result.");

  a_new_slab: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NEW) |-> (offset == '0 && slab_num == 4'(slabs_open - 5'd1)))
    else $error("New slab reported at the wrong index or offset.");

endmodule

bind slab_bump_allocator sba_checker u_sba_checker (.*);
